>>> sv/cfgcrc_pkg.sv
// Shared types and constants for the configurable CRC-16/CRC-32 engine.
package cfgcrc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ALL_ONES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_INPUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUTPUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_XOR_ONES = 3'd4;

  // Widest register is a single bit
  localparam int unsigned CFG_DATA_W = 1;

  // Polynomials and masks
  localparam logic [15:0] POLY16 = 16'h1021;
  localparam logic [31:0] POLY32 = 32'h04C1_1DB7;
  localparam logic [31:0] MASK16 = 32'h0000_FFFF;
  localparam logic [31:0] MASK32 = 32'hFFFF_FFFF;

  // Live configuration
  typedef struct packed {
    logic wide_mode;
    logic init_all_ones;
    logic reflect_input;
    logic reflect_output;
    logic final_xor_ones;
  } cfg_t;

endpackage

>>> sv/cfgcrc_in_if.sv
// Message byte channel: one data byte and a last-byte flag per word.
interface cfgcrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/cfgcrc_out_if.sv
// Result channel: one finalised CRC per word.
interface cfgcrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

>>> sv/cfgcrc_update.sv
// Byte-wide CRC update: eight MSB-first shift steps, 16- or 32-bit polynomial.
module cfgcrc_update (
  input  cfgcrc_pkg::cfg_t cfg,
  input  logic [31:0]      crc,
  input  logic [7:0]       data_byte,
  output logic [31:0]      crc_next
);
  import cfgcrc_pkg::*;

  logic [7:0]  b;
  logic [31:0] r32;
  logic [15:0] r16;

  // optional bit reversal of the incoming byte
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = cfg.reflect_input ? data_byte[7-i] : data_byte[i];
    end
  end

  // unrolled shift steps for both widths
  always_comb begin
    r32 = crc ^ {b, 24'h00_0000};
    r16 = crc[15:0] ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r32 = r32[31] ? ({r32[30:0], 1'b0} ^ POLY32) : {r32[30:0], 1'b0};
      r16 = r16[15] ? ({r16[14:0], 1'b0} ^ POLY16) : {r16[14:0], 1'b0};
    end
    crc_next = cfg.wide_mode ? r32 : {16'h0000, r16};
  end

endmodule

>>> sv/cfgcrc_finalize.sv
// Finalisation: optional reversal over the active width, then optional inversion.
module cfgcrc_finalize (
  input  cfgcrc_pkg::cfg_t cfg,
  input  logic [31:0]      crc,
  output logic [31:0]      crc_value
);
  import cfgcrc_pkg::*;

  logic [31:0] rev32;
  logic [15:0] rev16;
  logic [31:0] sel;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      rev32[i] = crc[31-i];
    end
    for (int i = 0; i < 16; i++) begin
      rev16[i] = crc[15-i];
    end
  end

  // mask to the active width, then invert within it
  always_comb begin
    if (cfg.wide_mode) begin
      sel = cfg.reflect_output ? rev32 : crc;
      crc_value = cfg.final_xor_ones ? (sel ^ MASK32) : sel;
    end else begin
      sel = cfg.reflect_output ? {16'h0000, rev16} : (crc & MASK16);
      crc_value = cfg.final_xor_ones ? (sel ^ MASK16) : sel;
    end
  end

endmodule

>>> sv/configurable_crc16_crc32.sv
// Configurable CRC-16-CCITT / CRC-32 engine, top level.
// Takes one message byte per cycle on msg and returns one finalised CRC on crc
// for each byte flagged last. A byte is held in an input register, then folded
// into the running CRC register (eight combinational shift steps); a last byte
// also loads the result register, and a new byte is taken every cycle. The
// running register feeds back on itself, which sets the one-byte-per-cycle rate.
// Only a last byte waits for the result register, and only while a previous
// result is still untaken. Configuration is written via cfg_wr_en, cfg_index
// and cfg_data (bit 0) by the user, who must do so only while the block is idle;
// the block itself does not enforce this. The first byte of each message starts
// from the initial value of the configuration then live.
module configurable_crc16_crc32 (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [cfgcrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfgcrc_pkg::CFG_DATA_W-1:0]    cfg_data,
  cfgcrc_in_if.sink                            msg,
  cfgcrc_out_if.source                         crc
);
  import cfgcrc_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic [31:0] crc_reg;
  logic        start;
  logic        out_valid;
  logic [31:0] out_value;

  logic [31:0] init_value;
  logic [31:0] base;
  logic [31:0] upd;
  logic [31:0] fin;
  logic        adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wide_mode      <= 1'b0;
      cfg.init_all_ones  <= 1'b1;
      cfg.reflect_input  <= 1'b0;
      cfg.reflect_output <= 1'b0;
      cfg.final_xor_ones <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDE_MODE:      cfg.wide_mode      <= cfg_data[0];
        CFG_INIT_ALL_ONES:  cfg.init_all_ones  <= cfg_data[0];
        CFG_REFLECT_INPUT:  cfg.reflect_input  <= cfg_data[0];
        CFG_REFLECT_OUTPUT: cfg.reflect_output <= cfg_data[0];
        CFG_FINAL_XOR_ONES: cfg.final_xor_ones <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the input stage moves on unless a last byte finds the result register full
  assign adv       = s1_valid && (!s1_last || !out_valid || crc.ready);
  assign msg.ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_byte <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
  end

  // starting value: initial value on the first byte of a message
  always_comb begin
    if (!cfg.init_all_ones) begin
      init_value = '0;
    end else begin
      init_value = cfg.wide_mode ? MASK32 : MASK16;
    end
  end
  assign base = start ? init_value : crc_reg;

  cfgcrc_update u_update (
    .cfg       (cfg),
    .crc       (base),
    .data_byte (s1_byte),
    .crc_next  (upd)
  );

  cfgcrc_finalize u_finalize (
    .cfg       (cfg),
    .crc       (upd),
    .crc_value (fin)
  );

  // running CRC and message-start flag
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= MASK32;
      start   <= 1'b1;
    end else if (adv) begin
      crc_reg <= upd;
      start   <= s1_last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (crc.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      out_value <= fin;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = out_value;

`ifndef SYNTH
  // a last byte blocked by a full result register stays in the input stage
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && out_valid && !crc.ready |=> s1_valid && s1_last)
    else $error("last byte dropped while result register full");

  // finishing a message always produces a result
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    adv && s1_last |=> out_valid)
    else $error("finished message gave no result");

  // start flag follows the last-byte flag of the byte just processed
  a_start_track: assert property (@(posedge clk) disable iff (rst)
    adv |=> start == $past(s1_last))
    else $error("message start flag out of step");

  // narrow mode keeps the upper half of the running CRC clear
  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    adv && !cfg.wide_mode |=> crc_reg[31:16] == 16'h0000)
    else $error("upper CRC bits set in 16-bit mode");
`endif

endmodule

>>> test/configurable_crc16_crc32_test.sv
// Self-checking testbench for the configurable CRC-16/CRC-32 engine.
module configurable_crc16_crc32_test;
  import cfgcrc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1850;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned END_WAIT_MAX = 5000;
  localparam int unsigned REPORT_MAX   = 10;

  // Indexes that select no register
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfgcrc_in_if  msg_if ();
  cfgcrc_out_if crc_if ();

  configurable_crc16_crc32 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .msg       (msg_if),
    .crc       (crc_if)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: live settings, running CRC, start-of-message flag
  cfg_t        live_cfg;
  logic [31:0] running_crc;
  logic        at_msg_start;
  logic [31:0] crc_expect_q[$];

  int unsigned words_sent = 0;
  int unsigned mismatch_count = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_gen = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic [31:0] want_crc;

  function automatic logic [31:0] reverse_bits(input logic [31:0] v, input int width);
    logic [31:0] r;
    int i;
    r = '0;
    for (i = 0; i < width; i++) r[width-1-i] = v[i];
    return r;
  endfunction

  function automatic logic [31:0] start_value();
    if (!live_cfg.init_all_ones) return '0;
    return live_cfg.wide_mode ? MASK32 : MASK16;
  endfunction

  function automatic void reset_predictor();
    live_cfg = '{wide_mode: 1'b0, init_all_ones: 1'b1, reflect_input: 1'b0,
                 reflect_output: 1'b0, final_xor_ones: 1'b1};
    running_crc = MASK32;
    at_msg_start = 1'b1;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WIDE_MODE:      live_cfg.wide_mode = d[0];
      CFG_INIT_ALL_ONES:  live_cfg.init_all_ones = d[0];
      CFG_REFLECT_INPUT:  live_cfg.reflect_input = d[0];
      CFG_REFLECT_OUTPUT: live_cfg.reflect_output = d[0];
      CFG_FINAL_XOR_ONES: live_cfg.final_xor_ones = d[0];
      default: ;
    endcase
  endfunction

  // Fold one accepted word into the running CRC; queue the result on a last byte
  function automatic void fold_byte(input logic [7:0] b, input logic lst);
    logic [7:0]  v;
    logic [31:0] r;
    logic [15:0] r16;
    logic [31:0] res;
    logic [31:0] mask;
    int i;
    if (at_msg_start) running_crc = start_value();
    v = live_cfg.reflect_input ? 8'(reverse_bits({24'h0, b}, 8)) : b;
    if (live_cfg.wide_mode) begin
      r = running_crc ^ {v, 24'h0};
      for (i = 0; i < 8; i++) r = r[31] ? ((r << 1) ^ POLY32) : (r << 1);
    end else begin
      r16 = running_crc[15:0] ^ {v, 8'h0};
      for (i = 0; i < 8; i++) r16 = r16[15] ? ((r16 << 1) ^ POLY16) : (r16 << 1);
      r = {16'h0, r16};
    end
    running_crc = r;
    if (!lst) begin
      at_msg_start = 1'b0;
    end else begin
      mask = live_cfg.wide_mode ? MASK32 : MASK16;
      res = r & mask;
      if (live_cfg.reflect_output) res = reverse_bits(res, live_cfg.wide_mode ? 32 : 16);
      if (live_cfg.final_xor_ones) res = res ^ mask;
      crc_expect_q.push_back(res & mask);
      at_msg_start = 1'b1;
      running_crc = start_value();
    end
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s: expected %08h, got %08h", what, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && crc_if.valid && crc_if.ready) begin
      if (crc_expect_q.size() == 0) begin
        note_failure("unexpected crc word", 'x, crc_if.crc_value);
      end else begin
        want_crc = crc_expect_q.pop_front();
        if (crc_if.crc_value !== want_crc)
          note_failure("crc_value mismatch", want_crc, crc_if.crc_value);
      end
    end
  end

  // Result ready: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      crc_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      crc_if.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(99) < 19) begin
      crc_if.ready <= 1'b0;
    end else begin
      crc_if.ready <= 1'b1;
    end
  end

  // Offer one word, with a random gap first; valid stays high on return
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (gaps_on && $urandom_range(99) < 19) begin
      msg_if.valid <= 1'b0;
      @(posedge clk);
    end
    msg_if.valid <= 1'b1;
    msg_if.data_byte <= b;
    msg_if.last_byte <= lst;
    do @(posedge clk); while (!msg_if.ready);
    fold_byte(b, lst);
    words_sent++;
  endtask

  // Stop offering, let every expected result arrive, then let the pipeline settle
  task automatic wait_idle();
    msg_if.valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    store_setting(idx, d);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_WIDE_MODE, c.wide_mode);
    write_reg(CFG_INIT_ALL_ONES, c.init_all_ones);
    write_reg(CFG_REFLECT_INPUT, c.reflect_input);
    write_reg(CFG_REFLECT_OUTPUT, c.reflect_output);
    write_reg(CFG_FINAL_XOR_ONES, c.final_xor_ones);
    // occasional write to an unused index
    if ($urandom_range(7) == 0)
      write_reg(CFG_IDX_W'($urandom_range(7, 5)), CFG_DATA_W'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Random message; optionally changes one register partway through
  task automatic send_message(input int len, input bit change_mid);
    int i;
    int split;
    split = (len > 1) ? $urandom_range(len - 1, 1) : 0;
    for (i = 0; i < len; i++) begin
      if (change_mid && i == split) begin
        wait_idle();
        write_reg(CFG_IDX_W'($urandom_range(4)), CFG_DATA_W'($urandom_range(1)));
      end
      send_byte(pick_byte(), i == len - 1);
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_setting_extremes();
    wait_idle();
    apply_settings('0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
    apply_settings('1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h31, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Width and reflection changes between words of one message
  task automatic test_mid_message_change();
    wait_idle();
    apply_settings('{wide_mode: 1'b1, init_all_ones: 1'b1, reflect_input: 1'b0,
                     reflect_output: 1'b0, final_xor_ones: 1'b1});
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    wait_idle();
    write_reg(CFG_WIDE_MODE, 1'b0);
    send_byte(8'h56, 1'b1);
    send_byte(8'h9C, 1'b0);
    wait_idle();
    write_reg(CFG_WIDE_MODE, 1'b1);
    write_reg(CFG_REFLECT_INPUT, 1'b1);
    send_byte(8'hE7, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_NO_REG_LO, 1'b1);
    write_reg(CFG_NO_REG_HI, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b1);
  endtask

  // Receiver holds off while short messages keep coming, so the input stalls
  task automatic test_result_backpressure();
    int i;
    wait_idle();
    apply_settings(cfg_t'(5'($urandom_range(31))));
    hold_gen <= hold_gen + 1;
    for (i = 0; i < 40; i++) send_message($urandom_range(2, 1), 1'b0);
  endtask

  // Sender pauses until the block has returned everything
  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 8; i++) send_message($urandom_range(4, 1), 1'b0);
    wait_idle();
    for (i = 0; i < 8; i++) send_message($urandom_range(4, 1), 1'b0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int len;
    int unsigned r;
    int unsigned phase_end;
    cfg_t c;
    phase = 0;
    while (words_sent < ITEM_TARGET) begin
      wait_idle();
      if (phase == 0) c = '0;
      else if (phase == 1) c = '1;
      else c = cfg_t'(5'($urandom_range(31)));
      apply_settings(c);
      // one phase runs with no gaps on either side
      gaps_on = (phase != 4);
      phase_end = words_sent + 100;
      while (words_sent < phase_end) begin
        r = $urandom_range(99);
        if (r < 70) len = $urandom_range(6, 1);
        else if (r < 95) len = $urandom_range(20, 7);
        else len = $urandom_range(64, 21);
        send_message(len, len > 1 && $urandom_range(9) == 0);
      end
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned end_wait;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    msg_if.valid = 1'b0;
    msg_if.data_byte = '0;
    msg_if.last_byte = 1'b0;
    reset_predictor();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_setting_extremes();
    test_mid_message_change();
    test_unused_index();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic();

    // drain with a bound, then let the pipeline settle
    msg_if.valid <= 1'b0;
    end_wait = 0;
    while (crc_expect_q.size() != 0 && end_wait < END_WAIT_MAX) begin
      @(posedge clk);
      end_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (crc_expect_q.size() != 0)
      note_failure("crc words never returned", crc_expect_q.size(), '0);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
